@@ sv/tssu_pkg.sv @@
// tssu_pkg: shared constants, codes and the thread table entry type
// for the thread time-slice and sleep unit
// no dependencies
`default_nettype none

package tssu_pkg;

    // sizing and kernel limits
    localparam int THREAD_SLOTS = 8;
    localparam int POOL_BYTES   = 2048;
    localparam int MIN_STACK    = 64;
    localparam int MIN_SLICE    = 1;
    localparam int IDLE_STACK   = 192;

    localparam int TID_W = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
    localparam int CNT_W = $clog2(THREAD_SLOTS + 1);

    // idle stack size after the minimum and even rounding
    localparam int IDLE_MIN  = (IDLE_STACK < MIN_STACK) ? MIN_STACK : IDLE_STACK;
    localparam int IDLE_SIZE = (IDLE_MIN + 1) & ~1;
    localparam bit IDLE_FITS = (IDLE_SIZE <= POOL_BYTES);

    // event codes
    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_SELECT = 3'd1;
    localparam logic [2:0] ACT_SLEEP  = 3'd2;
    localparam logic [2:0] ACT_QUANT  = 3'd3;
    localparam logic [2:0] ACT_CREATE = 3'd4;
    localparam logic [2:0] ACT_QUERY  = 3'd5;

    // thread states
    localparam logic [2:0] ST_UNUSED   = 3'd0;
    localparam logic [2:0] ST_READY    = 3'd1;
    localparam logic [2:0] ST_RUNNING  = 3'd2;
    localparam logic [2:0] ST_SLEEPING = 3'd3;
    localparam logic [2:0] ST_ZOMBIE   = 3'd4;

    // one row of the thread table
    typedef struct packed {
        logic [2:0]  state;
        logic [7:0]  slice_length;
        logic [7:0]  slice_left;
        logic [31:0] cpu_ticks;
        logic [7:0]  wake;
    } entry_t;

endpackage

`default_nettype wire

@@ sv/tssu_ram.sv @@
// tssu_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module tssu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ sv/thread_time_slice_sleep_unit.sv @@
// thread_time_slice_sleep_unit: per-thread slice, sleep and cpu tick table
// depends on tssu_pkg and tssu_ram
`default_nettype none

// Handles one kernel event per input beat and returns one result beat. The
// per-thread table sits in a single ram (one read, one write port, registered
// read); rows never written since reset read as their reset value through a
// row of valid flags. Select, sleep, set quantum, create, query and unknown
// events read one row and write it back only when the event changes it;
// query and unknown events write nothing. A tick sweeps every live thread
// through the ram port, one row per cycle with read and write-back
// overlapped. The next input beat is taken while a finished result still
// waits on the output register.
module thread_time_slice_sleep_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_action,
    input  wire logic [2:0]  s_thread_id,
    input  wire logic [7:0]  s_tick_value,
    input  wire logic [15:0] s_stack_bytes,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_ok,
    output logic             m_switch_now,
    output logic [2:0]       m_new_thread,
    output logic [7:0]       m_quantum_out,
    output logic [31:0]      m_cpu_ticks_out,
    output logic [3:0]       m_live_threads
);

    import tssu_pkg::*;

    localparam logic [2:0] FSM_IDLE  = 3'd0;
    localparam logic [2:0] FSM_READ  = 3'd1;
    localparam logic [2:0] FSM_EXEC  = 3'd2;
    localparam logic [2:0] FSM_SWEEP = 3'd3;
    localparam logic [2:0] FSM_OUT   = 3'd4;

    localparam logic [17:0] MIN_STACK_W = 18'(MIN_STACK);
    localparam logic [17:0] POOL_W      = 18'(POOL_BYTES);
    localparam logic [7:0]  MIN_SLICE_W = 8'(MIN_SLICE);

    logic [2:0]        fsm_reg, fsm_next;
    logic [2:0]        act_reg, act_next;
    logic [2:0]        tid_reg, tid_next;
    logic [7:0]        tv_reg, tv_next;
    logic [15:0]       sb_reg, sb_next;
    logic [TID_W-1:0]  run_reg, run_next;
    logic [CNT_W-1:0]  total_reg, total_next;
    logic [15:0]       pool_reg, pool_next;
    logic [THREAD_SLOTS-1:0] vld_reg, vld_next;
    logic [TID_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              pend_reg, pend_next;
    logic              res_ok_reg, res_ok_next;
    logic              res_sw_reg, res_sw_next;
    logic [2:0]        res_nt_reg, res_nt_next;
    logic [7:0]        res_q_reg, res_q_next;
    logic [31:0]       res_ct_reg, res_ct_next;
    logic              m_valid_reg, m_valid_next;
    logic              m_ok_reg, m_ok_next;
    logic              m_sw_reg, m_sw_next;
    logic [2:0]        m_nt_reg, m_nt_next;
    logic [7:0]        m_q_reg, m_q_next;
    logic [31:0]       m_ct_reg, m_ct_next;
    logic [3:0]        m_live_reg, m_live_next;

    logic              ram_we;
    logic [TID_W-1:0]  ram_waddr;
    entry_t            ram_wdata;
    logic [TID_W-1:0]  ram_raddr;
    entry_t            ram_rdata;

    entry_t            dflt;
    entry_t            cur;
    entry_t            tk;
    logic              tk_sw;
    logic              tid_ok;
    logic [7:0]        q_clamp;
    logic [17:0]       sz_min;
    logic [17:0]       sz_even;
    logic [17:0]       pool_sum;
    logic              rd_ok;
    logic              out_free;

    tssu_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (THREAD_SLOTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // reset value of a row never written
    always_comb begin
        dflt.state        = (idx_reg == '0 && IDLE_FITS) ? ST_READY : ST_UNUSED;
        dflt.slice_length = MIN_SLICE_W;
        dflt.slice_left   = MIN_SLICE_W;
        dflt.cpu_ticks    = '0;
        dflt.wake         = '0;
    end

    assign cur    = vld_reg[idx_reg] ? ram_rdata : dflt;
    assign tid_ok = (8'(tid_reg) < 8'(total_reg)) && (cur.state != ST_UNUSED);
    assign q_clamp = (tv_reg < MIN_SLICE_W) ? MIN_SLICE_W : tv_reg;

    // stack size: minimum, even rounding, pool check without wrap
    assign sz_min   = (18'(sb_reg) < MIN_STACK_W) ? MIN_STACK_W : 18'(sb_reg);
    assign sz_even  = (sz_min + 18'd1) & ~18'd1;
    assign pool_sum = 18'(pool_reg) + sz_even;

    // per-row tick update: charge the running thread, count down sleepers
    always_comb begin
        tk    = cur;
        tk_sw = 1'b0;
        if (idx_reg == run_reg) begin
            if (cur.state != ST_UNUSED) begin
                tk.cpu_ticks = cur.cpu_ticks + 32'd1;
                if (cur.slice_left > 8'd1) begin
                    tk.slice_left = cur.slice_left - 8'd1;
                end else begin
                    tk.slice_left = cur.slice_length;
                    tk_sw         = 1'b1;
                end
            end else begin
                tk_sw = 1'b1;
            end
        end
        if (cur.state == ST_SLEEPING) begin
            if (cur.wake != 8'd0) begin
                tk.wake = cur.wake - 8'd1;
            end
            if (tk.wake == 8'd0) begin
                tk.state = ST_READY;
            end
        end
    end

    assign rd_ok    = rd_idx_reg < total_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (fsm_reg == FSM_IDLE);

    // event sequencer
    always_comb begin
        fsm_next     = fsm_reg;
        act_next     = act_reg;
        tid_next     = tid_reg;
        tv_next      = tv_reg;
        sb_next      = sb_reg;
        run_next     = run_reg;
        total_next   = total_reg;
        pool_next    = pool_reg;
        vld_next     = vld_reg;
        idx_next     = idx_reg;
        rd_idx_next  = rd_idx_reg;
        pend_next    = pend_reg;
        res_ok_next  = res_ok_reg;
        res_sw_next  = res_sw_reg;
        res_nt_next  = res_nt_reg;
        res_q_next   = res_q_reg;
        res_ct_next  = res_ct_reg;
        m_valid_next = m_valid_reg;
        m_ok_next    = m_ok_reg;
        m_sw_next    = m_sw_reg;
        m_nt_next    = m_nt_reg;
        m_q_next     = m_q_reg;
        m_ct_next    = m_ct_reg;
        m_live_next  = m_live_reg;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg;
        ram_wdata    = cur;
        ram_raddr    = idx_reg;

        // output register drains independently
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (fsm_reg)
            FSM_IDLE: begin
                if (s_valid) begin
                    act_next    = s_action;
                    tid_next    = s_thread_id;
                    tv_next     = s_tick_value;
                    sb_next     = s_stack_bytes;
                    res_ok_next = 1'b0;
                    res_sw_next = 1'b0;
                    res_nt_next = '0;
                    res_q_next  = '0;
                    res_ct_next = '0;
                    rd_idx_next = '0;
                    pend_next   = 1'b0;
                    fsm_next    = (s_action == ACT_TICK) ? FSM_SWEEP : FSM_READ;
                end
            end
            FSM_READ: begin
                case (act_reg)
                    ACT_SLEEP:  ram_raddr = run_reg;
                    ACT_CREATE: ram_raddr = TID_W'(total_reg);
                    default:    ram_raddr = TID_W'(tid_reg);
                endcase
                idx_next = ram_raddr;
                fsm_next = FSM_EXEC;
            end
            FSM_EXEC: begin
                fsm_next = FSM_OUT;
                unique case (act_reg)
                    ACT_SELECT: begin
                        if (tid_ok) begin
                            run_next             = idx_reg;
                            ram_wdata.slice_left = cur.slice_length;
                            ram_we               = 1'b1;
                            res_ok_next          = 1'b1;
                        end
                    end
                    ACT_SLEEP: begin
                        res_ok_next = 1'b1;
                        res_sw_next = 1'b1;
                        if (tv_reg != 8'd0) begin
                            ram_wdata.wake  = tv_reg;
                            ram_wdata.state = ST_SLEEPING;
                            ram_we          = 1'b1;
                        end
                    end
                    ACT_QUANT: begin
                        if (tid_ok) begin
                            ram_wdata.slice_length = q_clamp;
                            if (cur.slice_left > q_clamp) begin
                                ram_wdata.slice_left = q_clamp;
                            end
                            ram_we      = 1'b1;
                            res_ok_next = 1'b1;
                        end
                    end
                    ACT_CREATE: begin
                        if (sb_reg != 16'd0 && total_reg < CNT_W'(THREAD_SLOTS)
                                && pool_sum <= POOL_W) begin
                            ram_wdata.state        = ST_READY;
                            ram_wdata.slice_length = MIN_SLICE_W;
                            ram_wdata.slice_left   = MIN_SLICE_W;
                            ram_wdata.wake         = '0;
                            ram_we                 = 1'b1;
                            pool_next              = pool_sum[15:0];
                            total_next             = total_reg + CNT_W'(1);
                            res_nt_next            = 3'(total_reg);
                            res_ok_next            = 1'b1;
                        end
                    end
                    ACT_QUERY: begin
                        if (tid_ok) begin
                            res_q_next  = cur.slice_length;
                            res_ct_next = cur.cpu_ticks;
                            res_ok_next = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            FSM_SWEEP: begin
                // read the next row while writing back the previous one
                ram_raddr   = TID_W'(rd_idx_reg);
                pend_next   = rd_ok;
                idx_next    = TID_W'(rd_idx_reg);
                res_ok_next = 1'b1;
                if (rd_ok) begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_wdata = tk;
                    if (tk_sw) begin
                        res_sw_next = 1'b1;
                    end
                end
                if (!rd_ok) begin
                    fsm_next = FSM_OUT;
                end
            end
            FSM_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_ok_next    = res_ok_reg;
                    m_sw_next    = res_sw_reg;
                    m_nt_next    = res_nt_reg;
                    m_q_next     = res_q_reg;
                    m_ct_next    = res_ct_reg;
                    m_live_next  = 4'(total_reg);
                    fsm_next     = FSM_IDLE;
                end
            end
            default: begin
                fsm_next = FSM_IDLE;
            end
        endcase

        if (ram_we) begin
            vld_next[ram_waddr] = 1'b1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg     <= FSM_IDLE;
            run_reg     <= '0;
            total_reg   <= CNT_W'(1);
            pool_reg    <= IDLE_FITS ? 16'(IDLE_SIZE) : 16'd0;
            vld_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            fsm_reg     <= fsm_next;
            run_reg     <= run_next;
            total_reg   <= total_next;
            pool_reg    <= pool_next;
            vld_reg     <= vld_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload and scratch registers
    always_ff @(posedge aclk) begin
        act_reg    <= act_next;
        tid_reg    <= tid_next;
        tv_reg     <= tv_next;
        sb_reg     <= sb_next;
        idx_reg    <= idx_next;
        rd_idx_reg <= rd_idx_next;
        res_ok_reg <= res_ok_next;
        res_sw_reg <= res_sw_next;
        res_nt_reg <= res_nt_next;
        res_q_reg  <= res_q_next;
        res_ct_reg <= res_ct_next;
        m_ok_reg   <= m_ok_next;
        m_sw_reg   <= m_sw_next;
        m_nt_reg   <= m_nt_next;
        m_q_reg    <= m_q_next;
        m_ct_reg   <= m_ct_next;
        m_live_reg <= m_live_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_ok            = m_ok_reg;
    assign m_switch_now    = m_sw_reg;
    assign m_new_thread    = m_nt_reg;
    assign m_quantum_out   = m_q_reg;
    assign m_cpu_ticks_out = m_ct_reg;
    assign m_live_threads  = m_live_reg;

endmodule

`default_nettype wire

@@ sv/tssu_checker.sv @@
// tssu_checker: port-level checks on the thread time-slice and sleep unit
// and the bind that attaches them; depends on thread_time_slice_sleep_unit
`default_nettype none

module tssu_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [2:0]  s_action,
    input wire logic [2:0]  s_thread_id,
    input wire logic [7:0]  s_tick_value,
    input wire logic [15:0] s_stack_bytes,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_ok,
    input wire logic        m_switch_now,
    input wire logic [2:0]  m_new_thread,
    input wire logic [7:0]  m_quantum_out,
    input wire logic [31:0] m_cpu_ticks_out,
    input wire logic [3:0]  m_live_threads
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cpu_ticks_out)
            && $stable(m_ok) && $stable(m_live_threads))
        else $error("result beat changed while stalled");

    // the unit works on one event at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an event is in progress");

    // a failed event reports nothing else
    a_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ok |-> !m_switch_now && m_new_thread == 3'd0
            && m_quantum_out == 8'd0 && m_cpu_ticks_out == 32'd0)
        else $error("failed event carries data");

    // a new thread number comes only from a successful create
    a_create: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_new_thread != 3'd0 |-> m_ok && !m_switch_now
            && m_quantum_out == 8'd0 && m_cpu_ticks_out == 32'd0)
        else $error("create result mixed with other data");

    // a switch request comes only from tick or sleep
    a_switch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_switch_now |-> m_ok && m_new_thread == 3'd0
            && m_quantum_out == 8'd0 && m_cpu_ticks_out == 32'd0)
        else $error("switch request with query or create data");

endmodule

bind thread_time_slice_sleep_unit tssu_checker u_tssu_checker (.*);

`default_nettype wire

@@ tb/sv/thread_time_slice_sleep_unit_tb.sv @@
// thread_time_slice_sleep_unit_tb: self-checking bench for the thread slice and sleep unit,
// a directed table of kernel events followed by weighted random events
// depends on tssu_pkg and thread_time_slice_sleep_unit
module thread_time_slice_sleep_unit_tb;
    import tssu_pkg::*;

    // reserved event codes, must be refused
    localparam logic [2:0] ACT_RSVD6 = 3'd6;
    localparam logic [2:0] ACT_RSVD7 = 3'd7;

    localparam int RANDOM_EVENTS  = 1400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PRINT_CAP      = 50;

    typedef struct packed {
        logic        ok;
        logic        switch_now;
        logic [2:0]  new_thread;
        logic [7:0]  quantum;
        logic [31:0] cpu_ticks;
        logic [3:0]  live;
    } event_reply_t;

    typedef struct {
        logic [2:0]   act;
        logic [2:0]   tid;
        logic [7:0]   ticks;
        logic [15:0]  stack;
        bit           typed;
        event_reply_t want;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_action = '0;
    logic [2:0]  s_thread_id = '0;
    logic [7:0]  s_tick_value = '0;
    logic [15:0] s_stack_bytes = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_ok;
    logic        m_switch_now;
    logic [2:0]  m_new_thread;
    logic [7:0]  m_quantum_out;
    logic [31:0] m_cpu_ticks_out;
    logic [3:0]  m_live_threads;

    thread_time_slice_sleep_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_thread_id    (s_thread_id),
        .s_tick_value   (s_tick_value),
        .s_stack_bytes  (s_stack_bytes),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_ok           (m_ok),
        .m_switch_now   (m_switch_now),
        .m_new_thread   (m_new_thread),
        .m_quantum_out  (m_quantum_out),
        .m_cpu_ticks_out(m_cpu_ticks_out),
        .m_live_threads (m_live_threads)
    );

    // 10 unit clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow copy of the thread table
    logic [2:0]  thr_state  [THREAD_SLOTS];
    logic [7:0]  quantum_tbl[THREAD_SLOTS];
    logic [7:0]  slice_rem  [THREAD_SLOTS];
    logic [31:0] cpu_ticks  [THREAD_SLOTS];
    logic [7:0]  wake_cnt   [THREAD_SLOTS];
    logic [3:0]  live_cnt;
    logic [2:0]  cur_thread;
    int          stack_used;

    event_reply_t pending_replies[$];
    stim_row_t    event_table[$];
    int           mismatches = 0;
    int           send_idle_pct = 32;
    int           recv_idle_pct = 75;
    int           quiet_cycles = 0;

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("mismatch on %s: got %0h, want %0h at %0t", field, got, want, $time);
    endtask

    task automatic add_row(input logic [2:0] act, input logic [2:0] tid,
                           input logic [7:0] ticks, input logic [15:0] stack,
                           input bit typed, input logic ok, input logic sw,
                           input logic [2:0] nt, input logic [7:0] q,
                           input logic [31:0] ct, input logic [3:0] live);
        stim_row_t r;
        r.act   = act;
        r.tid   = tid;
        r.ticks = ticks;
        r.stack = stack;
        r.typed = typed;
        r.want  = '{ok, sw, nt, q, ct, live};
        event_table.push_back(r);
    endtask

    function automatic bit thread_live(input logic [2:0] t);
        return ({1'b0, t} < live_cnt) && (thr_state[t] != ST_UNUSED);
    endfunction

    // applies one kernel event to the shadow table and returns its reply
    function automatic event_reply_t apply_kernel_event(input logic [2:0] act,
                                                        input logic [2:0] tid,
                                                        input logic [7:0] ticks,
                                                        input logic [15:0] stack);
        event_reply_t r;
        logic [7:0]   qv;
        logic [2:0]   slot;
        int           sz;
        int           i;
        r = '0;
        case (act)
            ACT_TICK: begin
                r.ok = 1'b1;
                if (!thread_live(cur_thread)) begin
                    r.switch_now = 1'b1;
                end else begin
                    cpu_ticks[cur_thread] = cpu_ticks[cur_thread] + 32'd1;
                    if (slice_rem[cur_thread] > 8'd1) begin
                        slice_rem[cur_thread] = slice_rem[cur_thread] - 8'd1;
                    end else begin
                        slice_rem[cur_thread] = quantum_tbl[cur_thread];
                        r.switch_now = 1'b1;
                    end
                end
                // count down sleepers, wake on zero
                for (i = 0; i < live_cnt && i < THREAD_SLOTS; i++) begin
                    if (thr_state[i] == ST_SLEEPING) begin
                        if (wake_cnt[i] != 8'd0)
                            wake_cnt[i] = wake_cnt[i] - 8'd1;
                        if (wake_cnt[i] == 8'd0)
                            thr_state[i] = ST_READY;
                    end
                end
            end
            ACT_SELECT: begin
                if (thread_live(tid)) begin
                    cur_thread     = tid;
                    slice_rem[tid] = quantum_tbl[tid];
                    r.ok           = 1'b1;
                end
            end
            ACT_SLEEP: begin
                r.ok         = 1'b1;
                r.switch_now = 1'b1;
                if (ticks != 8'd0) begin
                    wake_cnt[cur_thread]  = ticks;
                    thr_state[cur_thread] = ST_SLEEPING;
                end
            end
            ACT_QUANT: begin
                if (thread_live(tid)) begin
                    qv = (ticks < MIN_SLICE) ? 8'(MIN_SLICE) : ticks;
                    quantum_tbl[tid] = qv;
                    if (slice_rem[tid] > qv)
                        slice_rem[tid] = qv;
                    r.ok = 1'b1;
                end
            end
            ACT_CREATE: begin
                if (stack != 16'd0 && live_cnt < THREAD_SLOTS) begin
                    // wide size so oversize requests cannot wrap
                    sz = (stack < MIN_STACK) ? MIN_STACK : int'(stack);
                    sz = (sz + 1) & ~1;
                    if (stack_used + sz <= POOL_BYTES) begin
                        slot              = live_cnt[2:0];
                        stack_used        = stack_used + sz;
                        thr_state[slot]   = ST_READY;
                        quantum_tbl[slot] = 8'(MIN_SLICE);
                        slice_rem[slot]   = 8'(MIN_SLICE);
                        wake_cnt[slot]    = 8'd0;
                        live_cnt          = live_cnt + 4'd1;
                        r.new_thread      = slot;
                        r.ok              = 1'b1;
                    end
                end
            end
            ACT_QUERY: begin
                if (thread_live(tid)) begin
                    r.quantum   = quantum_tbl[tid];
                    r.cpu_ticks = cpu_ticks[tid];
                    r.ok        = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.live = live_cnt;
        return r;
    endfunction

    // result side: random back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each result beat with the oldest prediction
    always @(posedge aclk) begin : result_check
        event_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("unexpected result beat", 32'd0, 32'd0);
            end else begin
                want = pending_replies.pop_front();
                if (m_ok !== want.ok)
                    report_mismatch("ok", m_ok, want.ok);
                if (m_switch_now !== want.switch_now)
                    report_mismatch("switch_now", m_switch_now, want.switch_now);
                if (m_new_thread !== want.new_thread)
                    report_mismatch("new_thread", m_new_thread, want.new_thread);
                if (m_quantum_out !== want.quantum)
                    report_mismatch("quantum_out", m_quantum_out, want.quantum);
                if (m_cpu_ticks_out !== want.cpu_ticks)
                    report_mismatch("cpu_ticks_out", m_cpu_ticks_out, want.cpu_ticks);
                if (m_live_threads !== want.live)
                    report_mismatch("live_threads", m_live_threads, want.live);
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [2:0] act;
        logic [2:0] tid;
        logic [7:0] ticks;
        logic [15:0] stack;
        event_reply_t predicted;
        int total;
        int n;
        int pick;

        // shadow state after reset: idle thread owns its stack
        for (n = 0; n < THREAD_SLOTS; n++) begin
            thr_state[n]   = ST_UNUSED;
            quantum_tbl[n] = 8'(MIN_SLICE);
            slice_rem[n]   = 8'(MIN_SLICE);
            cpu_ticks[n]   = 32'd0;
            wake_cnt[n]    = 8'd0;
        end
        live_cnt   = 4'd1;
        cur_thread = 3'd0;
        stack_used = 0;
        if (IDLE_SIZE <= POOL_BYTES) begin
            thr_state[0] = ST_READY;
            stack_used   = IDLE_SIZE;
        end

        // directed events; typed replies only where obvious
        add_row(ACT_QUERY,  3'd0, 8'd0,   16'd0,     1, 1, 0, 0, 8'(MIN_SLICE), 0, 1);
        add_row(ACT_QUERY,  3'd1, 8'hff,  16'hffff,  1, 0, 0, 0, 0, 0, 1);
        add_row(ACT_SELECT, 3'd7, 8'd0,   16'd0,     1, 0, 0, 0, 0, 0, 1);
        add_row(ACT_RSVD6,  3'd0, 8'hff,  16'hffff,  1, 0, 0, 0, 0, 0, 1);
        add_row(ACT_RSVD7,  3'd7, 8'd0,   16'd64,    1, 0, 0, 0, 0, 0, 1);
        add_row(ACT_CREATE, 3'd0, 8'd0,   16'd0,     1, 0, 0, 0, 0, 0, 1);
        add_row(ACT_CREATE, 3'd0, 8'd0,   16'hffff,  1, 0, 0, 0, 0, 0, 1);
        // rounds up to two bytes past the pool
        add_row(ACT_CREATE, 3'd0, 8'd0,   16'd1857,  1, 0, 0, 0, 0, 0, 1);
        add_row(ACT_CREATE, 3'd5, 8'd0,   16'd1,     1, 1, 0, 1, 0, 0, 2);
        add_row(ACT_CREATE, 3'd7, 8'd0,   16'd65,    1, 1, 0, 2, 0, 0, 3);
        add_row(ACT_QUANT,  3'd1, 8'd0,   16'd0,     1, 1, 0, 0, 0, 0, 3);
        add_row(ACT_QUANT,  3'd2, 8'hff,  16'd0,     1, 1, 0, 0, 0, 0, 3);
        add_row(ACT_QUANT,  3'd6, 8'd5,   16'd0,     1, 0, 0, 0, 0, 0, 3);
        add_row(ACT_SELECT, 3'd2, 8'd0,   16'd0,     1, 1, 0, 0, 0, 0, 3);
        add_row(ACT_QUERY,  3'd1, 8'd0,   16'd0,     1, 1, 0, 0, 8'(MIN_SLICE), 0, 3);
        add_row(ACT_TICK,   3'd0, 8'd0,   16'd0,     0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_QUERY,  3'd2, 8'd0,   16'd0,     0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_QUANT,  3'd2, 8'd2,   16'd0,     0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_TICK,   3'd0, 8'd0,   16'd0,     0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_TICK,   3'd0, 8'd0,   16'd0,     0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_SLEEP,  3'd0, 8'd0,   16'd0,     1, 1, 1, 0, 0, 0, 3);
        add_row(ACT_SLEEP,  3'd0, 8'd2,   16'd0,     1, 1, 1, 0, 0, 0, 3);
        add_row(ACT_TICK,   3'd0, 8'd0,   16'd0,     0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_TICK,   3'd0, 8'd0,   16'd0,     0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_TICK,   3'd0, 8'd0,   16'd0,     0, 0, 0, 0, 0, 0, 0);
        add_row(ACT_CREATE, 3'd0, 8'd0,   16'd200,   1, 1, 0, 3, 0, 0, 4);

        total = event_table.size() + RANDOM_EVENTS;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (n = 0; n < total; n++) begin
            // idle mix per third of the run
            if (n < total / 3) begin
                send_idle_pct = 32;
                recv_idle_pct = 75;
            end else if (n < 2 * total / 3) begin
                send_idle_pct = 75;
                recv_idle_pct = 32;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (n < event_table.size()) begin
                act   = event_table[n].act;
                tid   = event_table[n].tid;
                ticks = event_table[n].ticks;
                stack = event_table[n].stack;
            end else begin
                // weighted event mix, ticks dominate
                tid   = 3'($urandom_range(7));
                ticks = 8'($urandom_range(255));
                stack = 16'($urandom_range(65535));
                pick  = $urandom_range(99);
                if (pick < 36) begin
                    act = ACT_TICK;
                end else if (pick < 50) begin
                    act = ACT_SELECT;
                end else if (pick < 60) begin
                    act = ACT_SLEEP;
                    pick = $urandom_range(99);
                    if (pick < 60)
                        ticks = 8'($urandom_range(1, 6));
                    else if (pick < 80)
                        ticks = 8'd0;
                end else if (pick < 72) begin
                    act = ACT_QUANT;
                    if ($urandom_range(1) == 0)
                        ticks = 8'($urandom_range(4));
                end else if (pick < 82) begin
                    act = ACT_CREATE;
                    pick = $urandom_range(99);
                    if (pick < 70)
                        stack = 16'($urandom_range(1, 200));
                    else if (pick < 85)
                        stack = 16'($urandom_range(400));
                end else if (pick < 96) begin
                    act = ACT_QUERY;
                end else begin
                    act = ($urandom_range(1) == 0) ? ACT_RSVD6 : ACT_RSVD7;
                end
            end

            // sender gap before the beat
            while ($urandom_range(99) < send_idle_pct) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
            s_valid       <= 1'b1;
            s_action      <= act;
            s_thread_id   <= tid;
            s_tick_value  <= ticks;
            s_stack_bytes <= stack;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);

            predicted = apply_kernel_event(act, tid, ticks, stack);
            if (n < event_table.size() && event_table[n].typed)
                pending_replies.push_back(event_table[n].want);
            else
                pending_replies.push_back(predicted);
        end
        s_valid <= 1'b0;

        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ thread_time_slice_sleep_unit.f @@
sv/tssu_pkg.sv
sv/tssu_ram.sv
sv/thread_time_slice_sleep_unit.sv
sv/tssu_checker.sv
tb/sv/thread_time_slice_sleep_unit_tb.sv
